### design/desa_pkg.sv
`timescale 1ns / 1ps

package desa_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 16;
	localparam int unsigned ADDR_BITS_DEF   = 16;

	localparam logic [16:0] ARENA_MAX    = 17'd65536;
	localparam logic [9:0]  HEADER_BYTES = 10'd8;
	localparam logic [3:0]  ALIGN_LG_MIN = 4'd2;
	localparam logic [3:0]  ALIGN_LG_MAX = 4'd8;

	localparam logic [2:0]  REG_ARENA_SIZE = 3'd0;

	typedef enum logic [1:0] {
		CMD_ALLOC_LOW  = 2'd0,
		CMD_FREE_LOW   = 2'd1,
		CMD_ALLOC_HIGH = 2'd2,
		CMD_FREE_HIGH  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_COLLIDE = 2'd1,
		ST_ORDER   = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	// Control of one side's stack: clear empties it, push and pop move the chain.
	typedef struct packed {
		logic clear;
		logic push;
		logic pop;
	} stack_ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} stack_stat_t;

endpackage

### design/desa_cell.sv
`timescale 1ns / 1ps

module desa_cell #(
	parameter int unsigned DW = 33
) (
	input  logic                  clk,
	input  desa_pkg::stack_ctl_t  ctl,
	input  logic [DW-1:0]         from_prev,
	input  logic [DW-1:0]         from_next,
	output logic [DW-1:0]         q
);

	logic [DW-1:0] data_q;

	// Push takes the entry from the cell above, pop takes it from the cell below.
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			data_q <= from_prev;
		end else if (ctl.pop) begin
			data_q <= from_next;
		end
	end

	assign q = data_q;

endmodule

### design/desa_stack.sv
`timescale 1ns / 1ps

module desa_stack #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned DW    = 33
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  desa_pkg::stack_ctl_t   ctl,
	input  logic [DW-1:0]          push_data,
	output logic [DW-1:0]          top_data,
	output desa_pkg::stack_stat_t  stat
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [CW-1:0] count_q;
	logic [DW-1:0] cell_q [DEPTH];
	desa_pkg::stack_ctl_t cell_ctl;

	always_comb begin
		cell_ctl       = ctl;
		cell_ctl.clear = 1'b0;
		cell_ctl.push  = ctl.push && !ctl.clear && !stat.full;
		cell_ctl.pop   = ctl.pop && !ctl.clear && !stat.empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.clear) begin
			count_q <= '0;
		end else if (cell_ctl.push) begin
			count_q <= count_q + CW'(1);
		end else if (cell_ctl.pop) begin
			count_q <= count_q - CW'(1);
		end
	end

	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DW-1:0] prev_d;
		logic [DW-1:0] next_d;

		if (i == 0) begin : g_head
			assign prev_d = push_data;
		end else begin : g_body
			assign prev_d = cell_q[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_d = cell_q[i];
		end else begin : g_inner
			assign next_d = cell_q[i+1];
		end

		desa_cell #(.DW(DW)) u_cell (
			.clk       (clk),
			.ctl       (cell_ctl),
			.from_prev (prev_d),
			.from_next (next_d),
			.q         (cell_q[i])
		);
	end

	assign top_data = cell_q[0];

endmodule

### design/double_ended_stack_allocator_top.sv
`timescale 1ns / 1ps

// Double-ended stack allocator: carves one arena from both ends.
// Input stream (s_*): one command per transaction. s_tuser carries the command
// (alloc low, free low, alloc high, free high); s_tdata carries request size,
// alignment exponent and the handle to free.
// Output stream (m_*): exactly one result transaction per command, with the
// block address in m_tdata and the status code in m_tuser.
// Results are registered: the output register loads at the accepting edge.
// Throughput: one command per cycle unless stalled; the allocation checks and
// the tops are resolved in the accept cycle, and each side's saved entries live
// in a chain of cells that shifts by one place on every push or pop.
// Stall: results sit in an output register; while it is full and m_tready is
// low, s_tready drops and no command is taken. Nothing is lost or repeated.
// Reset: arena size returns to 65536 bytes, both tops and both stacks empty.
// No clearing pass: a write to the arena size register over the APB port
// reinitializes tops and stacks directly; write it only while idle.
module double_ended_stack_allocator_top #(
	parameter int unsigned STACK_DEPTH = desa_pkg::STACK_DEPTH_DEF,
	parameter int unsigned ADDR_BITS   = desa_pkg::ADDR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// command stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // [15:0] request_size, [19:16] align_log2, [35:20] handle
	input  logic [1:0]  s_tuser,  // [1:0] command
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [15:0] address
	output logic [1:0]  m_tuser   // [1:0] status
);

	localparam int unsigned AW = ADDR_BITS;
	localparam int unsigned DW = 17 + AW;

	// configuration
	logic [16:0] arena_q;
	logic        cfg_wr;
	logic [16:0] cfg_val;

	// allocator state
	logic [16:0] low_top_q;
	logic [16:0] high_top_q;

	// output register
	logic        m_tvalid_q;
	logic [15:0] m_addr_q;
	desa_pkg::status_t m_status_q;

	// stacks
	desa_pkg::stack_ctl_t  low_ctl, high_ctl;
	desa_pkg::stack_stat_t low_stat, high_stat;
	logic [DW-1:0] low_push, high_push, low_top_d, high_top_d;

	// decoded command
	logic               accept;
	desa_pkg::cmd_t     cmd;
	logic [15:0]        req_size;
	logic [3:0]         lg_raw, lg;
	logic [15:0]        handle;
	logic [8:0]         align;
	logic [9:0]         extra;
	logic [17:0]        amask;
	logic [AW-1:0]      handle_w;

	// low side arithmetic
	logic [17:0]        low_new;
	logic               low_coll;
	logic [17:0]        low_a;
	logic [AW-1:0]      low_a_w;

	// high side arithmetic
	logic [16:0]        need;
	logic [16:0]        high_diff;
	logic               high_coll;
	logic [17:0]        high_a;
	logic [AW-1:0]      high_a_w;

	// results of the current command
	logic [16:0]        low_top_nx, high_top_nx;
	logic [AW-1:0]      res_addr_w;
	desa_pkg::status_t  res_status;

	// --- configuration port ---
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == desa_pkg::REG_ARENA_SIZE);

	// Clear the two low bits and saturate at the largest arena.
	always_comb begin
		cfg_val = {pwdata[16:2], 2'b00};
		if (cfg_val > desa_pkg::ARENA_MAX) begin
			cfg_val = desa_pkg::ARENA_MAX;
		end
	end

	assign prdata = (paddr == desa_pkg::REG_ARENA_SIZE) ? {15'd0, arena_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_q <= desa_pkg::ARENA_MAX;
		end else if (cfg_wr) begin
			arena_q <= cfg_val;
		end
	end

	// --- command decode ---
	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign cmd      = desa_pkg::cmd_t'(s_tuser);
	assign req_size = s_tdata[15:0];
	assign lg_raw   = s_tdata[19:16];
	assign handle   = s_tdata[35:20];

	// Clamp the alignment exponent into its supported range.
	always_comb begin
		lg = lg_raw;
		if (lg_raw < desa_pkg::ALIGN_LG_MIN) begin
			lg = desa_pkg::ALIGN_LG_MIN;
		end else if (lg_raw > desa_pkg::ALIGN_LG_MAX) begin
			lg = desa_pkg::ALIGN_LG_MAX;
		end
	end

	assign align = 9'd1 << lg;
	assign extra = desa_pkg::HEADER_BYTES + {1'b0, align};
	assign amask = {9'h1FF, ~(align - 9'd1)};

	// Handles and stored addresses are compared at ADDR_BITS bits.
	logic [32:0] handle_ext, low_a_ext, high_a_ext, res_addr_ext;
	assign handle_ext = {17'd0, handle};
	assign handle_w   = handle_ext[AW-1:0];

	// Low side: block grows up from the low top.
	assign low_new  = {1'b0, low_top_q} + {2'b00, req_size} + {8'd0, extra};
	assign low_coll = low_new >= {1'b0, high_top_q};
	assign low_a    = ({1'b0, low_top_q} + {8'd0, extra}) & amask;
	assign low_a_ext = {15'd0, low_a};
	assign low_a_w   = low_a_ext[AW-1:0];

	// High side: block grows down, address is taken above the new high top.
	assign need      = {1'b0, req_size} + {7'd0, extra};
	assign high_diff = high_top_q - need;
	assign high_coll = (high_top_q < need) || (high_diff <= low_top_q);
	assign high_a    = ({1'b0, high_diff} + {8'd0, extra}) & amask;
	assign high_a_ext = {15'd0, high_a};
	assign high_a_w   = high_a_ext[AW-1:0];

	assign low_push  = {low_top_q, low_a_w};
	assign high_push = {high_top_q, high_a_w};

	// --- next state and result ---
	always_comb begin
		low_top_nx     = low_top_q;
		high_top_nx    = high_top_q;
		res_addr_w     = '0;
		res_status     = desa_pkg::ST_OK;
		low_ctl        = '0;
		high_ctl       = '0;
		low_ctl.clear  = cfg_wr;
		high_ctl.clear = cfg_wr;

		case (cmd)
			desa_pkg::CMD_ALLOC_LOW: begin
				if (low_stat.full) begin
					res_status = desa_pkg::ST_FULL;
				end else if (low_coll) begin
					res_status = desa_pkg::ST_COLLIDE;
				end else begin
					low_ctl.push = accept;
					low_top_nx   = low_new[16:0];
					res_addr_w   = low_a_w;
				end
			end
			desa_pkg::CMD_FREE_LOW: begin
				if (low_stat.empty || (low_top_d[AW-1:0] != handle_w)) begin
					res_status = desa_pkg::ST_ORDER;
				end else begin
					low_ctl.pop = accept;
					low_top_nx  = low_top_d[DW-1:AW];
				end
			end
			desa_pkg::CMD_ALLOC_HIGH: begin
				if (high_stat.full) begin
					res_status = desa_pkg::ST_FULL;
				end else if (high_coll) begin
					res_status = desa_pkg::ST_COLLIDE;
				end else begin
					high_ctl.push = accept;
					high_top_nx   = high_diff;
					res_addr_w    = high_a_w;
				end
			end
			desa_pkg::CMD_FREE_HIGH: begin
				if (high_stat.empty || (high_top_d[AW-1:0] != handle_w)) begin
					res_status = desa_pkg::ST_ORDER;
				end else begin
					high_ctl.pop = accept;
					high_top_nx  = high_top_d[DW-1:AW];
				end
			end
			default: begin
				res_status = desa_pkg::ST_OK;
			end
		endcase
	end

	assign res_addr_ext = 33'(res_addr_w);

	// Tops: reinitialize on an arena write, load the next value on each accepted command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_top_q  <= '0;
			high_top_q <= desa_pkg::ARENA_MAX;
		end else if (cfg_wr) begin
			low_top_q  <= '0;
			high_top_q <= cfg_val;
		end else if (accept) begin
			low_top_q  <= low_top_nx;
			high_top_q <= high_top_nx;
		end
	end

	// Output register: load on accept, drop valid once the result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_addr_q   <= res_addr_ext[15:0];
			m_status_q <= res_status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_addr_q;
	assign m_tuser  = m_status_q;

	// --- saved-entry stacks, one chain of cells per side ---
	desa_stack #(.DEPTH(STACK_DEPTH), .DW(DW)) u_low_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (low_ctl),
		.push_data (low_push),
		.top_data  (low_top_d),
		.stat      (low_stat)
	);

	desa_stack #(.DEPTH(STACK_DEPTH), .DW(DW)) u_high_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (high_ctl),
		.push_data (high_push),
		.top_data  (high_top_d),
		.stat      (high_stat)
	);

endmodule

### tb/desa_checker.sv
`timescale 1ns / 1ps

// Watches the APB port and both streams, tracks the arena state and compares
// every result transaction with the oldest expected one.
module desa_checker #(
	parameter int unsigned DEPTH = desa_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	input  logic [1:0]  m_tuser,
	output int          fail_count,
	output int          results_outstanding
);

	typedef struct {
		logic [15:0]       address;
		desa_pkg::status_t status;
	} alloc_result_t;

	alloc_result_t expected_results[$];

	logic [16:0] arena_bytes;
	logic [16:0] low_top, high_top;
	int unsigned low_depth, high_depth;
	logic [16:0] low_prev_top[DEPTH];
	logic [15:0] low_block[DEPTH];
	logic [16:0] high_prev_top[DEPTH];
	logic [15:0] high_block[DEPTH];
	int          mismatches;

	function automatic void rewind_arena();
		low_top    = '0;
		high_top   = arena_bytes;
		low_depth  = 0;
		high_depth = 0;
	endfunction

	function automatic alloc_result_t predict_command(desa_pkg::cmd_t cmd, logic [15:0] size,
			logic [3:0] lg_field, logic [15:0] handle);
		alloc_result_t res;
		int unsigned   lg, align, extra, grown, need, fresh_top, aligned;
		res.address = '0;
		res.status  = desa_pkg::ST_OK;
		lg = 32'(lg_field);
		if (lg < desa_pkg::ALIGN_LG_MIN) lg = 32'(desa_pkg::ALIGN_LG_MIN);
		if (lg > desa_pkg::ALIGN_LG_MAX) lg = 32'(desa_pkg::ALIGN_LG_MAX);
		align = 1 << lg;
		extra = desa_pkg::HEADER_BYTES + align;
		case (cmd)
			desa_pkg::CMD_ALLOC_LOW: begin
				grown = low_top + size + extra;
				if (low_depth >= DEPTH) begin
					res.status = desa_pkg::ST_FULL;
				end else if (grown >= high_top) begin
					res.status = desa_pkg::ST_COLLIDE;
				end else begin
					aligned = (low_top + extra) & ~(align - 1);
					low_prev_top[low_depth] = low_top;
					low_block[low_depth]    = aligned[15:0];
					low_depth++;
					low_top     = grown[16:0];
					res.address = aligned[15:0];
				end
			end
			desa_pkg::CMD_ALLOC_HIGH: begin
				need = size + extra;
				if (high_depth >= DEPTH) begin
					res.status = desa_pkg::ST_FULL;
				end else if (high_top < need || high_top - need <= low_top) begin
					res.status = desa_pkg::ST_COLLIDE;
				end else begin
					fresh_top = high_top - need;
					// an address of exactly 65536 wraps to zero here
					aligned = (fresh_top + extra) & ~(align - 1);
					high_prev_top[high_depth] = high_top;
					high_block[high_depth]    = aligned[15:0];
					high_depth++;
					high_top    = fresh_top[16:0];
					res.address = aligned[15:0];
				end
			end
			desa_pkg::CMD_FREE_LOW: begin
				if (low_depth == 0 || low_block[low_depth - 1] != handle) begin
					res.status = desa_pkg::ST_ORDER;
				end else begin
					low_depth--;
					low_top = low_prev_top[low_depth];
				end
			end
			default: begin
				if (high_depth == 0 || high_block[high_depth - 1] != handle) begin
					res.status = desa_pkg::ST_ORDER;
				end else begin
					high_depth--;
					high_top = high_prev_top[high_depth];
				end
			end
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t want;
		logic [16:0]   sized;
		if (!arst_n) begin
			arena_bytes = desa_pkg::ARENA_MAX;
			rewind_arena();
			expected_results.delete();
			mismatches = 0;
			fail_count <= 0;
			results_outstanding <= 0;
		end else begin
			if (psel && penable && pready && paddr == desa_pkg::REG_ARENA_SIZE) begin
				if (pwrite) begin
					sized = pwdata[16:0] & ~17'd3;
					arena_bytes = (sized > desa_pkg::ARENA_MAX) ? desa_pkg::ARENA_MAX : sized;
					rewind_arena();
				end else if (prdata !== {15'd0, arena_bytes}) begin
					$error("arena_size mismatch: expected %0d, actual %0d",
						arena_bytes, prdata);
					mismatches++;
				end
			end
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: address %h status %0d", m_tdata, m_tuser);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (m_tdata !== want.address) begin
						$error("address mismatch: expected %h, actual %h",
							want.address, m_tdata);
						mismatches++;
					end
					if (m_tuser !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							want.status, m_tuser);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(predict_command(desa_pkg::cmd_t'(s_tuser),
					s_tdata[15:0], s_tdata[19:16], s_tdata[35:20]));
			fail_count <= mismatches;
			results_outstanding <= expected_results.size();
		end
	end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

// Top of the allocator bench: drives commands and APB writes, throttles the
// result stream and reports the verdict. All checking lives in desa_checker.
module tb;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid, s_tready;
	logic [39:0] s_tdata;  // [15:0] request_size, [19:16] align_log2, [35:20] handle
	logic [1:0]  s_tuser;  // [1:0] command
	logic        m_tvalid, m_tready;
	logic [15:0] m_tdata;  // [15:0] address
	logic [1:0]  m_tuser;  // [1:0] status
	int          fail_count;
	int          results_outstanding;

	// Commands sent but not yet answered, and the live block addresses per side
	// as the block reported them; frees pick their handle from these.
	desa_pkg::cmd_t cmds_in_flight[$];
	logic [15:0]    low_handles[$];
	logic [15:0]    high_handles[$];
	int             send_calm, recv_calm;

	double_ended_stack_allocator_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	desa_checker checker_i (
		.clk                 (clk),
		.arst_n              (arst_n),
		.psel                (psel),
		.penable             (penable),
		.pwrite              (pwrite),
		.paddr               (paddr),
		.pwdata              (pwdata),
		.prdata              (prdata),
		.pready              (pready),
		.s_tvalid            (s_tvalid),
		.s_tready            (s_tready),
		.s_tdata             (s_tdata),
		.s_tuser             (s_tuser),
		.m_tvalid            (m_tvalid),
		.m_tready            (m_tready),
		.m_tdata             (m_tdata),
		.m_tuser             (m_tuser),
		.fail_count          (fail_count),
		.results_outstanding (results_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	// Idle length for one transaction: mostly a uniformly drawn gap, with occasional
	// stretches of back-to-back traffic.
	function automatic int draw_idle(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0) begin
			calm_left = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 18);
	endfunction

	// Follow the results so that frees can name the live block of a side.
	always @(posedge clk) begin
		desa_pkg::cmd_t done;
		if (m_tvalid && m_tready && cmds_in_flight.size() > 0) begin
			done = cmds_in_flight.pop_front();
			if (m_tuser == desa_pkg::ST_OK) begin
				case (done)
					desa_pkg::CMD_ALLOC_LOW:  low_handles.push_back(m_tdata);
					desa_pkg::CMD_ALLOC_HIGH: high_handles.push_back(m_tdata);
					desa_pkg::CMD_FREE_LOW:
						if (low_handles.size() > 0) void'(low_handles.pop_back());
					default:
						if (high_handles.size() > 0) void'(high_handles.pop_back());
				endcase
			end
		end
		if (s_tvalid && s_tready)
			cmds_in_flight.push_back(desa_pkg::cmd_t'(s_tuser));
	end

	// Result side: hold m_tready low for a random stall before each transaction.
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = draw_idle(recv_calm);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Present one command after a random gap and hold it until accepted.
	task automatic issue(desa_pkg::cmd_t cmd, logic [15:0] size, logic [3:0] lg,
			logic [15:0] handle);
		int gap;
		gap = draw_idle(send_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {4'd0, handle, lg, size};
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop valid and wait until every command has its result.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_outstanding != 0) @(posedge clk);
	endtask

	task automatic apb_access(logic write, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= desa_pkg::REG_ARENA_SIZE;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Resize the arena (only while idle) and read the size back.
	task automatic set_arena(logic [31:0] value);
		apb_access(1'b1, value);
		low_handles.delete();
		high_handles.delete();
		// hold the bus idle between the two transfers
		@(posedge clk);
		apb_access(1'b0, 32'd0);
	endtask

	// Free handle: mostly the side's live block, sometimes a wrong one.
	function automatic logic [15:0] pick_handle(desa_pkg::cmd_t cmd);
		logic [15:0] latest;
		int          live;
		live   = (cmd == desa_pkg::CMD_FREE_LOW) ? low_handles.size() : high_handles.size();
		latest = (live == 0) ? 16'd0 :
			(cmd == desa_pkg::CMD_FREE_LOW) ? low_handles[live - 1] : high_handles[live - 1];
		if (live > 0 && $urandom_range(0, 9) < 8)
			return latest;
		if ($urandom_range(0, 1) == 0)
			return latest ^ (16'd1 << $urandom_range(0, 15));
		return 16'($urandom);
	endfunction

	// Sizes: mostly small so stacks fill up, some medium, a few full range.
	function automatic logic [15:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 16'($urandom_range(0, 255));
		if (r < 90) return 16'($urandom_range(0, 4095));
		return 16'($urandom);
	endfunction

	function automatic logic [3:0] pick_align();
		if ($urandom_range(0, 9) == 0) return 4'($urandom_range(0, 15));
		return 4'($urandom_range(desa_pkg::ALIGN_LG_MIN, desa_pkg::ALIGN_LG_MAX));
	endfunction

	task automatic random_command();
		int             sel;
		desa_pkg::cmd_t cmd;
		sel = $urandom_range(0, 99);
		if (sel < 4) begin
			// noise: any command, any field
			issue(desa_pkg::cmd_t'($urandom_range(0, 3)), 16'($urandom),
				4'($urandom_range(0, 15)), 16'($urandom));
		end else if (sel < 68) begin
			cmd = (sel < 36) ? desa_pkg::CMD_ALLOC_LOW : desa_pkg::CMD_ALLOC_HIGH;
			issue(cmd, pick_size(), pick_align(), 16'($urandom));
		end else begin
			cmd = (sel < 84) ? desa_pkg::CMD_FREE_LOW : desa_pkg::CMD_FREE_HIGH;
			issue(cmd, 16'($urandom), 4'($urandom_range(0, 15)), pick_handle(cmd));
		end
	endtask

	initial begin
		logic [31:0] arena_plan[7];
		int          items_plan[7];
		logic [31:0] rnd_arena;

		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = desa_pkg::REG_ARENA_SIZE;
		pwdata   = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = desa_pkg::CMD_ALLOC_LOW;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: frees on empty sides, alignment clamped at both ends,
		// collisions from a full-range size, the high block landing on the
		// arena end (wraps to zero), out-of-order and in-order frees.
		issue(desa_pkg::CMD_FREE_LOW, 16'hFFFF, 4'hF, 16'h0000);
		issue(desa_pkg::CMD_FREE_HIGH, 16'h0000, 4'h0, 16'hFFFF);
		issue(desa_pkg::CMD_ALLOC_LOW, 16'h0000, 4'h0, 16'hFFFF);
		issue(desa_pkg::CMD_ALLOC_LOW, 16'hFFFF, 4'h8, 16'h0000);
		issue(desa_pkg::CMD_ALLOC_HIGH, 16'h0000, 4'hF, 16'h0000);
		issue(desa_pkg::CMD_ALLOC_HIGH, 16'hFFFF, 4'h2, 16'h0000);
		drain();
		issue(desa_pkg::CMD_FREE_HIGH, 16'd0, 4'd0,
			pick_handle(desa_pkg::CMD_FREE_HIGH) ^ 16'h0001);
		issue(desa_pkg::CMD_FREE_HIGH, 16'd0, 4'd0, pick_handle(desa_pkg::CMD_FREE_HIGH));
		issue(desa_pkg::CMD_FREE_LOW, 16'd0, 4'd0,
			pick_handle(desa_pkg::CMD_FREE_LOW) + 16'd4);
		drain();
		issue(desa_pkg::CMD_FREE_LOW, 16'd0, 4'd0, pick_handle(desa_pkg::CMD_FREE_LOW));
		// fill the low stack to its depth and one beyond
		for (int i = 0; i <= desa_pkg::STACK_DEPTH_DEF; i++)
			issue(desa_pkg::CMD_ALLOC_LOW, 16'(i), 4'd2, 16'd0);
		drain();

		// Random phases, each at its own arena size: full, small, tiny, zero,
		// saturating write, random value with random upper bits, narrow.
		rnd_arena     = $urandom;
		rnd_arena[16] = 1'b0;
		arena_plan = '{32'd65536, 32'd1024, 32'd4, 32'd3, 32'hFFFF_FFFF, rnd_arena, 32'd256};
		items_plan = '{150, 120, 15, 15, 150, 100, 50};
		foreach (arena_plan[p]) begin
			set_arena(arena_plan[p]);
			repeat (items_plan[p]) random_command();
			drain();
		end

		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
